>>> sv/afr_pkg.sv
package afr_pkg;

	localparam int BUFFER_BYTES_DEF = 128;
	localparam int COUNT_W = 8;
	localparam int CFG_INDEX_W = 1;
	localparam int HEADER_BYTES = 12;

	localparam logic [7:0] DELIMITER = 8'h7E;
	localparam logic [7:0] SUM_GOOD = 8'hFF;
	localparam logic [6:0] MAX_LENGTH_RST = 7'd127;
	localparam logic [7:0] ACCEPT_TYPE_RST = 8'h90;

	localparam logic [CFG_INDEX_W-1:0] REG_MAX_LENGTH = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ACCEPT_TYPE = 1'd1;

	typedef enum logic {
		OP_BYTE = 1'b0,
		OP_READ = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_NONE = 3'd0,
		ST_GOOD = 3'd1,
		ST_LENGTH = 3'd2,
		ST_CHECKSUM = 3'd3,
		ST_TYPE = 3'd4
	} status_t;

	typedef struct packed {
		op_t op;
		logic [7:0] rx_byte;
		logic [6:0] read_index;
	} in_word_t;

	typedef struct packed {
		status_t status;
		logic [6:0] pay_len;
		logic [7:0] read_data;
	} out_word_t;

	typedef struct packed {
		status_t status;
		logic [6:0] pay_len;
		logic hit;
	} stage1_t;

endpackage

>>> sv/afr_store.sv
module afr_store #(
	parameter int DEPTH = afr_pkg::BUFFER_BYTES_DEF
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [7:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [7:0] rdata
);
	import afr_pkg::*;

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_s1 <= mem[raddr];
		end
	end

	assign rdata = rdata_s1;

endmodule

>>> sv/afr_parser.sv
module afr_parser #(
	parameter int BUFFER_BYTES = afr_pkg::BUFFER_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic accept,
	input afr_pkg::in_word_t in_data,
	input logic cfg_write,
	input logic [afr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [7:0] cfg_data,
	output logic mem_we,
	output logic [$clog2(BUFFER_BYTES)-1:0] mem_waddr,
	output logic [7:0] mem_wdata,
	output logic mem_re,
	output logic [$clog2(BUFFER_BYTES)-1:0] mem_raddr,
	output afr_pkg::stage1_t stage_s1
);
	import afr_pkg::*;

	localparam int AW = $clog2(BUFFER_BYTES);
	localparam int LIMIT_CAP = (BUFFER_BYTES - 1 > 127) ? 127 : BUFFER_BYTES - 1;

	logic [6:0] max_length_q;
	logic [7:0] accept_type_q;
	logic frame_open_q, frame_open_d;
	logic [COUNT_W-1:0] count_q, count_d;
	logic [7:0] len_hi_q, len_hi_d;
	logic [6:0] len_q, len_d;
	logic [7:0] sum_q, sum_d;
	logic [7:0] type_q, type_d;
	logic [6:0] good_len_q, good_len_d;
	logic [6:0] limit;
	status_t status_d;
	logic hit_d;

	assign limit = (max_length_q > 7'(LIMIT_CAP)) ? 7'(LIMIT_CAP) : max_length_q;
	assign mem_wdata = in_data.rx_byte;
	assign mem_waddr = AW'(int'(count_q) - 2);
	assign mem_raddr = AW'(HEADER_BYTES + int'(in_data.read_index));

	always_comb begin
		frame_open_d = frame_open_q;
		count_d = count_q;
		len_hi_d = len_hi_q;
		len_d = len_q;
		sum_d = sum_q;
		type_d = type_q;
		good_len_d = good_len_q;
		status_d = ST_NONE;
		hit_d = 1'b0;
		mem_we = 1'b0;
		mem_re = 1'b0;
		if (accept) begin
			if (in_data.op == OP_READ) begin
				hit_d = in_data.read_index < good_len_q;
				mem_re = hit_d;
			end else if (!frame_open_q) begin
				if (in_data.rx_byte == DELIMITER) begin
					frame_open_d = 1'b1;
					count_d = '0;
					len_hi_d = '0;
					sum_d = '0;
				end
			end else begin
				priority if (count_q == COUNT_W'(0)) begin
					len_hi_d = in_data.rx_byte;
					count_d = COUNT_W'(1);
				end else if (count_q == COUNT_W'(1)) begin
					if (len_hi_q != 8'd0 || in_data.rx_byte < 8'(HEADER_BYTES) ||
						in_data.rx_byte > {1'b0, limit}) begin
						frame_open_d = 1'b0;
						status_d = ST_LENGTH;
					end else begin
						len_d = in_data.rx_byte[6:0];
						count_d = COUNT_W'(2);
					end
				end else begin
					mem_we = 1'b1;
					sum_d = sum_q + in_data.rx_byte;
					if (count_q == COUNT_W'(2)) begin
						type_d = in_data.rx_byte;
					end
					count_d = count_q + COUNT_W'(1);
					if (count_q == COUNT_W'(len_q) + COUNT_W'(2)) begin
						frame_open_d = 1'b0;
						if (sum_d != SUM_GOOD) begin
							status_d = ST_CHECKSUM;
						end else if (type_q != accept_type_q) begin
							status_d = ST_TYPE;
						end else begin
							good_len_d = len_q - 7'(HEADER_BYTES);
							status_d = ST_GOOD;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= MAX_LENGTH_RST;
			accept_type_q <= ACCEPT_TYPE_RST;
			frame_open_q <= 1'b0;
			count_q <= '0;
			len_hi_q <= '0;
			len_q <= '0;
			sum_q <= '0;
			type_q <= '0;
			good_len_q <= '0;
		end else begin
			if (cfg_write && cfg_index == REG_MAX_LENGTH) begin
				max_length_q <= cfg_data[6:0];
			end
			if (cfg_write && cfg_index == REG_ACCEPT_TYPE) begin
				accept_type_q <= cfg_data;
			end
			frame_open_q <= frame_open_d;
			count_q <= count_d;
			len_hi_q <= len_hi_d;
			len_q <= len_d;
			sum_q <= sum_d;
			type_q <= type_d;
			good_len_q <= good_len_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stage_s1.status <= status_d;
			stage_s1.pay_len <= good_len_d;
			stage_s1.hit <= hit_d;
		end
	end

endmodule

>>> sv/afr_out_skid.sv
module afr_out_skid (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input afr_pkg::out_word_t in_data,
	output logic out_valid,
	input logic out_ready,
	output afr_pkg::out_word_t out_data
);
	import afr_pkg::*;

	out_word_t entry_q [2];
	logic wptr_q, rptr_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign in_ready = cnt_q != 2'd2;
	assign out_valid = cnt_q != 2'd0;
	assign out_data = entry_q[rptr_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

>>> sv/api_frame_receiver.sv
// Receiver for serial API frames, one word per received byte or payload read.
// Input channel (in_valid, in_ready, in_data): op selects a received serial
// byte or a read of one payload byte as the buffer now holds it. Every input
// word gives exactly one output word on (out_valid, out_ready, out_data) with
// the frame status, the current good payload length and the read byte.
// The configuration channel is always ready and sets the largest accepted
// frame length and the accepted frame type; write it only while idle.
// An accepted word is registered in the frame state and buffer memory stage
// and then in the output queue before it can be taken on the output.
// Throughput is one word per cycle while the output queue is not full, set by
// the single write or read the buffer memory takes per word. A two-entry output
// queue keeps the input ready while one result waits; a stalled receiver fills
// the queue and then drops in_ready. Reset clears the frame state, the good
// payload length and the configuration to their defaults; the buffer contents
// are not cleared and are never returned before a good frame has been stored.
module api_frame_receiver #(
	parameter int BUFFER_BYTES = afr_pkg::BUFFER_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input afr_pkg::in_word_t in_data,
	output logic out_valid,
	input logic out_ready,
	output afr_pkg::out_word_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [afr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [7:0] cfg_data
);
	import afr_pkg::*;

	localparam int AW = $clog2(BUFFER_BYTES);

	logic valid_s1;
	logic skid_ready;
	logic accept;
	logic mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [7:0] mem_wdata, mem_rdata;
	stage1_t stage_s1;
	out_word_t result;

	assign cfg_ready = 1'b1;
	assign in_ready = !valid_s1 || skid_ready;
	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	afr_parser #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.in_data(in_data),
		.cfg_write(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re(mem_re),
		.mem_raddr(mem_raddr),
		.stage_s1(stage_s1)
	);

	afr_store #(
		.DEPTH(BUFFER_BYTES)
	) u_store (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign result.status = stage_s1.status;
	assign result.pay_len = stage_s1.pay_len;
	assign result.read_data = stage_s1.hit ? mem_rdata : 8'd0;

	afr_out_skid u_out_skid (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(valid_s1),
		.in_ready(skid_ready),
		.in_data(result),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

endmodule

>>> sim/tb_api_frame_receiver.sv
module tb_api_frame_receiver;
	import afr_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_CYCLES = 10;

	typedef struct {
		in_word_t word;
		bit typed;
		out_word_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_word_t in_data;
	logic out_valid;
	logic out_ready;
	out_word_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [7:0] cfg_data;

	bit frame_open;
	logic [7:0] byte_cnt;
	logic [15:0] frame_len;
	logic [7:0] byte_sum;
	logic [7:0] frame_buf [BUFFER_BYTES_DEF];
	logic [6:0] good_len;
	logic [6:0] max_len_reg;
	logic [7:0] accept_reg;

	out_word_t reports_due [$];
	dir_row_t dir_rows [$];
	out_word_t want_word;
	int send_idle_pct;
	int recv_idle_pct;
	int words_sent;
	int words_checked;
	int errors;
	int cycle_count;
	int settings_used;
	int status_tally [5];

	api_frame_receiver u_top (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_ready = ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			words_checked++;
			if (reports_due.size() == 0) begin
				$error("result word arrived with no expectation waiting");
				errors++;
			end else begin
				want_word = reports_due.pop_front();
				status_tally[int'(want_word.status)]++;
				if (out_data.status !== want_word.status) begin
					$error("status: expected %0d, got %0d", want_word.status, out_data.status);
					errors++;
				end
				if (out_data.pay_len !== want_word.pay_len) begin
					$error("pay_len: expected %0d, got %0d",
						want_word.pay_len, out_data.pay_len);
					errors++;
				end
				if (out_data.read_data !== want_word.read_data) begin
					$error("read_data: expected %0d, got %0d",
						want_word.read_data, out_data.read_data);
					errors++;
				end
			end
		end
	end

	function automatic out_word_t parse_word(input in_word_t w);
		out_word_t r;
		bit rejected;
		r = '0;
		r.status = ST_NONE;
		rejected = 1'b0;
		if (w.op == OP_READ) begin
			if (w.read_index < good_len)
				r.read_data = frame_buf[HEADER_BYTES + int'(w.read_index)];
		end else if (!frame_open) begin
			if (w.rx_byte == DELIMITER) begin
				frame_open = 1'b1;
				byte_cnt = '0;
				frame_len = '0;
				byte_sum = '0;
			end
		end else begin
			if (byte_cnt == 8'd0) begin
				frame_len = {w.rx_byte, 8'h00};
			end else if (byte_cnt == 8'd1) begin
				frame_len[7:0] = w.rx_byte;
				if (frame_len < HEADER_BYTES || frame_len > max_len_reg) begin
					frame_open = 1'b0;
					r.status = ST_LENGTH;
					rejected = 1'b1;
				end
			end else begin
				frame_buf[int'(byte_cnt) - 2] = w.rx_byte;
				byte_sum = byte_sum + w.rx_byte;
			end
			if (!rejected) begin
				byte_cnt = byte_cnt + 8'd1;
				if (int'(byte_cnt) == int'(frame_len) + 3) begin
					frame_open = 1'b0;
					if (byte_sum != SUM_GOOD) begin
						r.status = ST_CHECKSUM;
					end else if (frame_buf[0] != accept_reg) begin
						r.status = ST_TYPE;
					end else begin
						good_len = 7'(int'(frame_len) - HEADER_BYTES);
						r.status = ST_GOOD;
					end
				end
			end
		end
		r.pay_len = good_len;
		return r;
	endfunction

	task automatic add_row(input op_t op, input logic [7:0] b, input logic [6:0] idx,
		input bit typed, input status_t st, input logic [6:0] plen, input logic [7:0] rd);
		dir_row_t row;
		row.word.op = op;
		row.word.rx_byte = b;
		row.word.read_index = idx;
		row.typed = typed;
		row.want.status = st;
		row.want.pay_len = plen;
		row.want.read_data = rd;
		dir_rows.push_back(row);
	endtask

	task automatic push_word(input in_word_t w, input bit typed, input out_word_t want);
		out_word_t guess;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data = w;
		do @(posedge clk); while (!in_ready);
		guess = parse_word(w);
		reports_due.push_back(typed ? want : guess);
		words_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		in_word_t w;
		w.op = OP_BYTE;
		w.rx_byte = b;
		w.read_index = 7'($urandom_range(127));
		push_word(w, 1'b0, '0);
	endtask

	task automatic send_read();
		in_word_t w;
		int hi;
		hi = int'(good_len) + 2;
		if (hi > 127)
			hi = 127;
		w.op = OP_READ;
		w.rx_byte = 8'($urandom_range(255));
		if ($urandom_range(9) < 7)
			w.read_index = 7'($urandom_range(hi));
		else
			w.read_index = 7'($urandom_range(127));
		push_word(w, 1'b0, '0);
	endtask

	task automatic send_frame(input int flen, input bit type_ok, input bit sum_ok);
		logic [7:0] b;
		logic [7:0] total;
		total = 8'h00;
		send_byte(DELIMITER);
		send_byte(flen[15:8]);
		send_byte(flen[7:0]);
		for (int i = 0; i < flen; i++) begin
			if (i == 0)
				b = type_ok ? accept_reg : accept_reg ^ 8'($urandom_range(1, 255));
			else if ($urandom_range(19) == 0)
				b = DELIMITER;
			else
				b = 8'($urandom_range(255));
			total = total + b;
			send_byte(b);
			if ($urandom_range(99) < 12)
				send_read();
		end
		b = SUM_GOOD - total;
		if (!sum_ok)
			b = b + 8'($urandom_range(1, 255));
		send_byte(b);
	endtask

	task automatic run_random(input int n_words);
		int stop_at;
		int pick;
		int flen;
		int hi;
		stop_at = words_sent + n_words;
		while (words_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				hi = (max_len_reg < 30) ? int'(max_len_reg) : 30;
				if (max_len_reg < HEADER_BYTES)
					flen = HEADER_BYTES;
				else if ($urandom_range(4) != 0)
					flen = $urandom_range(HEADER_BYTES, hi);
				else
					flen = $urandom_range(HEADER_BYTES, max_len_reg);
				send_frame(flen, $urandom_range(99) < 85, $urandom_range(99) < 85);
			end else if (pick < 70) begin
				repeat ($urandom_range(1, 5)) send_read();
			end else if (pick < 82) begin
				case ($urandom_range(2))
					0: flen = $urandom_range(HEADER_BYTES - 1);
					1: flen = int'(max_len_reg) + $urandom_range(1, 2);
					default: flen = $urandom_range(int'(max_len_reg) + 1, 16'hFFFF);
				endcase
				send_byte(DELIMITER);
				send_byte(flen[15:8]);
				send_byte(flen[7:0]);
			end else if (pick < 93) begin
				repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(255)));
			end else begin
				send_byte(DELIMITER);
				repeat ($urandom_range(20)) send_byte(8'($urandom_range(255)));
			end
		end
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid = 1'b0;
		while (reports_due.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_MAX_LENGTH)
			max_len_reg = value[6:0];
		else
			accept_reg = value;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic run_phase(input logic [6:0] max_len, input logic [7:0] acc,
		input int send_pct, input int recv_pct, input int n_words);
		drain_results();
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		write_reg(REG_MAX_LENGTH, {1'b0, max_len});
		write_reg(REG_ACCEPT_TYPE, acc);
		settings_used++;
		run_random(n_words);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_MAX_LENGTH;
		cfg_data = 8'h00;
		send_idle_pct = 11;
		recv_idle_pct = 57;
		settings_used = 1;
		frame_open = 1'b0;
		byte_cnt = '0;
		frame_len = '0;
		byte_sum = '0;
		good_len = '0;
		max_len_reg = MAX_LENGTH_RST;
		accept_reg = ACCEPT_TYPE_RST;

		// Reads before any good frame, then rejected lengths at both ends.
		add_row(OP_READ, 8'h00, 7'd0, 1'b1, ST_NONE, 7'd0, 8'h00);
		add_row(OP_READ, 8'hFF, 7'd127, 1'b1, ST_NONE, 7'd0, 8'h00);
		add_row(OP_BYTE, 8'h00, 7'd127, 1'b1, ST_NONE, 7'd0, 8'h00);
		add_row(OP_BYTE, DELIMITER, 7'd0, 1'b0, ST_NONE, 7'd0, 8'h00);
		add_row(OP_BYTE, 8'h00, 7'd0, 1'b0, ST_NONE, 7'd0, 8'h00);
		add_row(OP_BYTE, 8'h0B, 7'd0, 1'b1, ST_LENGTH, 7'd0, 8'h00);
		add_row(OP_BYTE, DELIMITER, 7'd0, 1'b0, ST_NONE, 7'd0, 8'h00);
		add_row(OP_BYTE, 8'hFF, 7'd0, 1'b0, ST_NONE, 7'd0, 8'h00);
		add_row(OP_BYTE, 8'hFF, 7'd0, 1'b1, ST_LENGTH, 7'd0, 8'h00);
		// Shortest good frame, with a delimiter in its data and a read in the middle.
		add_row(OP_BYTE, DELIMITER, 7'd0, 1'b0, ST_NONE, 7'd0, 8'h00);
		add_row(OP_BYTE, 8'h00, 7'd0, 1'b0, ST_NONE, 7'd0, 8'h00);
		add_row(OP_BYTE, 8'h0C, 7'd0, 1'b0, ST_NONE, 7'd0, 8'h00);
		add_row(OP_BYTE, 8'h90, 7'd0, 1'b0, ST_NONE, 7'd0, 8'h00);
		add_row(OP_BYTE, DELIMITER, 7'd0, 1'b0, ST_NONE, 7'd0, 8'h00);
		add_row(OP_BYTE, 8'hFF, 7'd0, 1'b0, ST_NONE, 7'd0, 8'h00);
		add_row(OP_READ, 8'h00, 7'd5, 1'b0, ST_NONE, 7'd0, 8'h00);
		repeat (9) add_row(OP_BYTE, 8'h00, 7'd0, 1'b0, ST_NONE, 7'd0, 8'h00);
		add_row(OP_BYTE, 8'hF2, 7'd0, 1'b1, ST_GOOD, 7'd0, 8'h00);
		add_row(OP_READ, 8'h00, 7'd0, 1'b1, ST_NONE, 7'd0, 8'h00);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i])
			push_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
		run_random(250);
		run_phase(7'd12, 8'h00, 11, 57, 250);
		run_phase(7'd0, 8'hA5, 57, 11, 100);
		run_phase(7'd127, 8'hFF, 57, 11, 250);
		run_phase(7'd40, 8'h90, 0, 0, 350);
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d words, checked %0d results under %0d register settings.",
			words_sent, words_checked, settings_used);
		$display("Frames judged: %0d good, %0d bad length, %0d bad checksum, %0d bad type.",
			status_tally[ST_GOOD], status_tally[ST_LENGTH],
			status_tally[ST_CHECKSUM], status_tally[ST_TYPE]);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
